// ===== sv/ppts_pkg.sv =====
package ppts_pkg;

    // default size of the task table
    localparam int unsigned NUM_TASKS_DEF = 16;
    // slot index carried along the chain, wide enough for the largest table (256)
    localparam int unsigned SLOT_IDX_W = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  slot;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
    } t_in_word;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic        finished;
        logic [31:0] completion_time;
        logic [31:0] turnaround_time;
        logic [31:0] waiting_time;
        logic        all_done;
        logic [31:0] now_time;
    } t_out_word;

    // best candidate so far, handed from cell to cell during a tick scan
    typedef struct packed {
        logic                  found;
        logic [7:0]            urg;
        logic [SLOT_IDX_W-1:0] slot;
        logic [15:0]           arrival;
        logic [15:0]           burst;
        logic [15:0]           remaining;
        logic [1:0]            busy_cnt;   // busy slots seen, saturates at 2
    } t_cand;

endpackage

// ===== sv/ppts_cell.sv =====
module ppts_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  ppts_pkg::t_in_word   i_word,
    input  logic                 i_dec,
    input  logic [31:0]          i_time,
    input  logic                 i_vld,
    input  ppts_pkg::t_cand      i_cand,
    output logic                 o_vld,
    output ppts_pkg::t_cand      o_cand
);

    logic [15:0]     r_arr;
    logic [15:0]     r_bst;
    logic [7:0]      r_urg;
    logic [15:0]     r_rem;
    logic            r_vld;
    ppts_pkg::t_cand r_cand;
    ppts_pkg::t_cand n_cand;

    logic rem_nz;
    logic eligible;
    logic win;

    assign rem_nz   = (r_rem != 16'd0);
    assign eligible = rem_nz && ({16'd0, r_arr} <= i_time);
    // strict less-than keeps the earlier (lower) slot on a tie
    assign win      = eligible && (!i_cand.found || (r_urg < i_cand.urg));

    always_comb begin
        n_cand = i_cand;
        if (win) begin
            n_cand.found     = 1'b1;
            n_cand.urg       = r_urg;
            n_cand.slot      = ppts_pkg::SLOT_IDX_W'(IDX);
            n_cand.arrival   = r_arr;
            n_cand.burst     = r_bst;
            n_cand.remaining = r_rem;
        end
        n_cand.busy_cnt = (i_cand.busy_cnt == 2'd2) ? 2'd2
                                                    : i_cand.busy_cnt + {1'b0, rem_nz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 16'd0;
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (i_we) begin
                r_rem <= i_word.burst_time;
            end else if (i_dec) begin
                r_rem <= r_rem - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_arr <= i_word.arrival_time;
            r_bst <= i_word.burst_time;
            r_urg <= i_word.priority_req;
        end
        r_cand <= n_cand;
    end

    assign o_vld  = r_vld;
    assign o_cand = r_cand;

endmodule

// ===== sv/preemptive_priority_task_scheduler.sv =====
// Preemptive priority task scheduler. A word is taken when i_start is high and
// o_busy is low. A load word (cmd = load) writes one task slot and o_busy
// stays low; it produces no result. A tick word scans the task table through
// a chain of NUM_TASKS cells, one cell per cycle, then updates the picked slot
// and the time counter and then forms the result. The result appears on
// o_result for exactly one cycle with o_done high and cannot be held off, so
// the receiver must take it in that cycle; o_busy drops in the same cycle, so
// the next word may follow at once. Loads to a slot beyond the table are
// dropped. Reset is synchronous and active low.
module preemptive_priority_task_scheduler #(
    parameter int unsigned NUM_TASKS = ppts_pkg::NUM_TASKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ppts_pkg::t_in_word   i_word,
    output logic                 o_busy,
    output logic                 o_done,
    output ppts_pkg::t_out_word  o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC
    } t_state;

    t_state r_state;
    logic   r_busy;

    logic [31:0]                     r_time;
    logic [31:0]                     n_time;
    logic                            r_found;
    logic [ppts_pkg::SLOT_IDX_W-1:0] r_slot;
    logic                            r_fin;
    logic [31:0]                     r_turn;
    logic [15:0]                     r_bst;
    logic                            r_alld;

    logic                            accept;
    logic                            tick_go;
    logic                            load_go;
    logic                            fin_now;
    logic [31:0]                     wait_val;

    logic                            w_vld  [NUM_TASKS+1];
    ppts_pkg::t_cand                 w_cand [NUM_TASKS+1];
    logic [NUM_TASKS-1:0]            w_vld_vec;
    ppts_pkg::t_cand                 w_last;
    logic                            w_last_vld;

    assign accept  = i_start && !r_busy;
    assign tick_go = accept && (i_word.cmd == ppts_pkg::CMD_TICK);
    assign load_go = accept && (i_word.cmd == ppts_pkg::CMD_LOAD);

    assign w_vld[0]  = tick_go;
    assign w_cand[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NUM_TASKS; k++) begin : g_cell
            logic cell_we;
            logic cell_dec;
            assign cell_we  = load_go &&
                (ppts_pkg::SLOT_IDX_W'(i_word.slot) == ppts_pkg::SLOT_IDX_W'(k));
            assign cell_dec = w_last_vld && w_last.found &&
                (w_last.slot == ppts_pkg::SLOT_IDX_W'(k));
            assign w_vld_vec[k] = w_vld[k+1];

            ppts_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_we    (cell_we),
                .i_word  (i_word),
                .i_dec   (cell_dec),
                .i_time  (r_time),
                .i_vld   (w_vld[k]),
                .i_cand  (w_cand[k]),
                .o_vld   (w_vld[k+1]),
                .o_cand  (w_cand[k+1])
            );
        end
    endgenerate

    assign w_last     = w_cand[NUM_TASKS];
    assign w_last_vld = w_vld[NUM_TASKS];

    assign n_time   = (r_time != 32'hFFFF_FFFF) ? r_time + 32'd1 : r_time;
    assign fin_now  = w_last.found && (w_last.remaining == 16'd1);
    assign wait_val = (r_turn >= {16'd0, r_bst}) ? r_turn - {16'd0, r_bst} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_time  <= 32'd0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (tick_go) begin
                        r_state <= S_SCAN;
                        r_busy  <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_last_vld) begin
                        r_state <= S_CALC;
                        r_time  <= n_time;
                    end
                end
                S_CALC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    o_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // payload of the update and output stages
    always_ff @(posedge i_clk) begin
        if (w_last_vld) begin
            r_found <= w_last.found;
            r_slot  <= w_last.slot;
            r_fin   <= fin_now;
            r_turn  <= n_time - {16'd0, w_last.arrival};
            r_bst   <= w_last.burst;
            // the finishing slot drops out of the busy count
            r_alld  <= !(w_last.busy_cnt[1] || ((w_last.busy_cnt == 2'd1) && !fin_now));
        end
        if (r_state == S_CALC) begin
            o_result.ran_valid       <= r_found;
            o_result.ran_slot        <= r_found ? r_slot[3:0] : 4'd0;
            o_result.finished        <= r_fin;
            o_result.completion_time <= r_fin ? r_time : 32'd0;
            o_result.turnaround_time <= r_fin ? r_turn : 32'd0;
            o_result.waiting_time    <= r_fin ? wait_val : 32'd0;
            o_result.all_done        <= r_alld;
            o_result.now_time        <= r_time;
        end
    end

    assign o_busy = r_busy;

`ifndef NO_ASSERTIONS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld_vec) <= 1)
        else $error("more than one scan token in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (w_vld_vec == '0))
        else $error("scan token present while not busy");

    a_done_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_state == S_CALC))
        else $error("result strobe without an output stage");

    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("time counter went backward");

    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.finished) |-> (o_result.ran_valid && !$past(o_done)))
        else $error("completion reported without a running task");
`endif

endmodule
